>>> src/ttss_pkg.sv
// Shared constants, codes and types of the timed task slot scheduler.
package ttss_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int OUT_SLOT_W = 6;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  localparam logic [1:0] KIND_ACCEPT   = 2'd0;
  localparam logic [1:0] KIND_REJECT   = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_TICK,
    OP_FLUSH,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] task_id;
    logic [31:0] delay_ms;
    logic        run_on_main;
    logic [31:0] elapsed_ms;
  } cmd_t;

endpackage

>>> src/ttss_front.sv
// Input side: accepts stream transfers, decodes the mode and queues commands.
module ttss_front import ttss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [IN_DATA_W-1:0] s_data_i,
  input  logic [1:0]           s_mode_i,
  output cmd_t                 cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_pop_i
);

  localparam int QD    = 2;
  localparam int PTR_W = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  cmd_t             q_mem [QD];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [QC_W-1:0]  cnt_q;
  cmd_t             cmd_in;
  logic             push;
  logic             pop;

  always_comb begin
    cmd_in.task_id     = s_data_i[15:0];
    cmd_in.delay_ms    = s_data_i[47:16];
    cmd_in.run_on_main = s_data_i[48];
    cmd_in.elapsed_ms  = s_data_i[80:49];
    case (s_mode_i)
      MODE_INSERT: cmd_in.op = OP_INSERT;
      MODE_TICK:   cmd_in.op = OP_TICK;
      MODE_FLUSH:  cmd_in.op = OP_FLUSH;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign s_ready_o   = (cnt_q != QC_W'(QD));
  assign push        = s_valid_i && s_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QC_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QC_W'(1);
      end
    end
  end

endmodule

>>> src/ttss_back.sv
// Execution side: slot pool, free stack, timer walk and result register.
module ttss_back import ttss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  par_en_i,
  input  cmd_t                  cmd_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_kind_o,
  output logic [15:0]           out_task_o,
  output logic                  out_main_o,
  output logic [OUT_SLOT_W-1:0] out_slot_o,
  output logic                  out_last_o,
  output logic [CNT_W-1:0]      free_cnt_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [SLOTS-1:0]  busy_q;
  logic [SLOTS-1:0]  fs_vld_q;
  logic [CNT_W-1:0]  free_cnt_q;
  logic [SLOT_W-1:0] fs_mem [SLOTS];
  logic [SLOT_W-1:0] fs_rd_q;
  logic [SLOT_W-1:0] fs_ra_q;
  logic              fs_rv_q;

  logic [31:0] rem_mem  [SLOTS];
  logic [15:0] task_mem [SLOTS];
  logic        main_mem [SLOTS];
  logic [31:0] rem_rd_q;
  logic [15:0] task_rd_q;
  logic        main_rd_q;

  logic [15:0] task_q;
  logic [31:0] delay_q;
  logic        main_q;
  logic [31:0] elapsed_q;
  logic        flush_q;

  logic [CNT_W-1:0]  idx_q;
  logic              s1_vld_q;
  logic              s1_busy_q;
  logic [SLOT_W-1:0] s1_idx_q;

  logic              pend_vld_q;
  logic [15:0]       pend_task_q;
  logic              pend_main_q;
  logic [SLOT_W-1:0] pend_slot_q;

  logic                  out_valid_q;
  logic [1:0]            out_kind_q;
  logic [15:0]           out_task_q;
  logic                  out_main_q;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic                  out_last_q;

  logic              out_free;
  logic              due;
  logic              hit;
  logic              stall;
  logic              issue;
  logic              pop;
  logic              fs_re;
  logic              alloc_we;
  logic              sub_we;
  logic              push;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] fs_slot;
  logic [CNT_W-1:0]  cnt_dec;
  logic [SLOT_W-1:0] fs_raddr;
  logic [SLOT_W-1:0] rem_waddr;
  logic [31:0]       rem_wdata;
  logic              hit_main;

  assign out_free  = !out_valid_q || out_ready_i;
  assign due       = flush_q || (rem_rd_q <= elapsed_q);
  assign hit       = s1_vld_q && s1_busy_q && due;
  assign stall     = hit && pend_vld_q && !out_free;
  assign issue     = (state_q == ST_WALK) && !stall && (idx_q < CNT_W'(SLOTS));
  assign rd_idx    = idx_q[SLOT_W-1:0];
  assign fs_slot   = fs_rv_q ? fs_rd_q : fs_ra_q;
  assign cnt_dec   = free_cnt_q - CNT_W'(1);
  assign fs_raddr  = cnt_dec[SLOT_W-1:0];
  assign pop       = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign fs_re     = pop && (cmd_i.op == OP_INSERT) && (free_cnt_q != '0);
  assign alloc_we  = (state_q == ST_ALLOC) && out_free;
  assign sub_we    = (state_q == ST_WALK) && s1_vld_q && s1_busy_q && !due;
  assign push      = (state_q == ST_WALK) && hit && !stall;
  assign rem_waddr = alloc_we ? fs_slot : s1_idx_q;
  assign rem_wdata = alloc_we ? delay_q : (rem_rd_q - elapsed_q);
  assign hit_main  = main_rd_q || !par_en_i;

  always_ff @(posedge clk_i) begin
    if (alloc_we || sub_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (alloc_we) begin
      task_mem[fs_slot] <= task_q;
      main_mem[fs_slot] <= main_q;
    end
    if (issue) begin
      rem_rd_q  <= rem_mem[rd_idx];
      task_rd_q <= task_mem[rd_idx];
      main_rd_q <= main_mem[rd_idx];
    end
    if (push) begin
      fs_mem[free_cnt_q[SLOT_W-1:0]] <= s1_idx_q;
    end
    if (fs_re) begin
      fs_rd_q <= fs_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      fs_vld_q    <= '0;
      free_cnt_q  <= CNT_W'(SLOTS);
      fs_ra_q     <= '0;
      fs_rv_q     <= 1'b0;
      task_q      <= '0;
      delay_q     <= '0;
      main_q      <= 1'b0;
      elapsed_q   <= '0;
      flush_q     <= 1'b0;
      idx_q       <= '0;
      s1_vld_q    <= 1'b0;
      s1_busy_q   <= 1'b0;
      s1_idx_q    <= '0;
      pend_vld_q  <= 1'b0;
      pend_task_q <= '0;
      pend_main_q <= 1'b0;
      pend_slot_q <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_NONE;
      out_task_q  <= '0;
      out_main_q  <= 1'b0;
      out_slot_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            case (cmd_i.op)
              OP_INSERT: begin
                if (free_cnt_q == '0) begin
                  out_valid_q <= 1'b1;
                  out_kind_q  <= KIND_REJECT;
                  out_task_q  <= '0;
                  out_main_q  <= 1'b0;
                  out_slot_q  <= '0;
                  out_last_q  <= 1'b1;
                end else begin
                  free_cnt_q <= cnt_dec;
                  fs_ra_q    <= fs_raddr;
                  fs_rv_q    <= fs_vld_q[fs_raddr];
                  task_q     <= cmd_i.task_id;
                  delay_q    <= cmd_i.delay_ms;
                  main_q     <= cmd_i.run_on_main;
                  state_q    <= ST_ALLOC;
                end
              end
              OP_TICK, OP_FLUSH: begin
                flush_q    <= (cmd_i.op == OP_FLUSH);
                elapsed_q  <= cmd_i.elapsed_ms;
                idx_q      <= '0;
                s1_vld_q   <= 1'b0;
                pend_vld_q <= 1'b0;
                state_q    <= ST_WALK;
              end
              default: begin
                out_valid_q <= 1'b1;
                out_kind_q  <= KIND_NONE;
                out_task_q  <= '0;
                out_main_q  <= 1'b0;
                out_slot_q  <= '0;
                out_last_q  <= 1'b1;
              end
            endcase
          end
        end
        ST_ALLOC: begin
          if (out_free) begin
            busy_q[fs_slot] <= 1'b1;
            out_valid_q     <= 1'b1;
            out_kind_q      <= KIND_ACCEPT;
            out_task_q      <= '0;
            out_main_q      <= 1'b0;
            out_slot_q      <= OUT_SLOT_W'(fs_slot);
            out_last_q      <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (!stall) begin
            if (hit) begin
              busy_q[s1_idx_q]                     <= 1'b0;
              fs_vld_q[free_cnt_q[SLOT_W-1:0]]     <= 1'b1;
              free_cnt_q                           <= free_cnt_q + CNT_W'(1);
              if (pend_vld_q) begin
                out_valid_q <= 1'b1;
                out_kind_q  <= KIND_DISPATCH;
                out_task_q  <= pend_task_q;
                out_main_q  <= pend_main_q;
                out_slot_q  <= OUT_SLOT_W'(pend_slot_q);
                out_last_q  <= 1'b0;
              end
              pend_vld_q  <= 1'b1;
              pend_task_q <= task_rd_q;
              pend_main_q <= hit_main;
              pend_slot_q <= s1_idx_q;
            end
            if (issue) begin
              s1_vld_q  <= 1'b1;
              s1_idx_q  <= rd_idx;
              s1_busy_q <= busy_q[rd_idx];
              idx_q     <= idx_q + CNT_W'(1);
            end else begin
              s1_vld_q <= 1'b0;
              state_q  <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            if (pend_vld_q) begin
              out_kind_q <= KIND_DISPATCH;
              out_task_q <= pend_task_q;
              out_main_q <= pend_main_q;
              out_slot_q <= OUT_SLOT_W'(pend_slot_q);
            end else begin
              out_kind_q <= KIND_NONE;
              out_task_q <= '0;
              out_main_q <= 1'b0;
              out_slot_q <= '0;
            end
            pend_vld_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cmd_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_task_o  = out_task_q;
  assign out_main_o  = out_main_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;
  assign free_cnt_o  = free_cnt_q;

endmodule

>>> src/timed_task_slot_scheduler_unit.sv
// An accepted insert passes from the input queue through ST_ALLOC to the output register;
// a rejected insert or an unused mode goes from the queue straight to the output register.
// A tick or flush walks one slot per cycle through the slot memory read port while the
// result side does not stall it; no new command is taken until an insert or walk is done.
// Results leave through a one-entry output register; two commands queue at the input.
// Reset clears all busy flags, restores the free stack to slot i at entry i and sets
// parallel_enabled to 1; there is no clearing pass.
module timed_task_slot_scheduler_unit import ttss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // task_id[15:0], delay_ms[47:16], run_on_main[48], elapsed_ms[80:49], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_task_id[15:0], to_main[16], slot_index[22:17], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i
);

  logic                  par_en_q;
  cmd_t                  cmd;
  logic                  cmd_valid;
  logic                  cmd_pop;
  logic [15:0]           out_task;
  logic                  out_main;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]      free_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      par_en_q <= cfg_wdata_i;
    end
  end

  ttss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_mode_i    (s_axis_tuser),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  ttss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .par_en_i    (par_en_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_task_o  (out_task),
    .out_main_o  (out_main),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast),
    .free_cnt_o  (free_cnt)
  );

  assign m_axis_tdata = {1'b0, out_slot, out_main, out_task};

  a_free_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt <= CNT_W'(SLOTS))
    else $error("free slot count exceeds the pool size");

  a_reject_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_REJECT)) |-> (free_cnt == '0))
    else $error("insert rejected while free slots remain");

  a_single_results_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_DISPATCH)) |-> m_axis_tlast)
    else $error("non-dispatch result without tlast");

endmodule
